// ===== rtl/mhpq_pkg.sv =====
// ============================================================================
// mhpq_pkg
// Shared types and constants for the min-heap priority queue: beat structs,
// status and action codes, and the control word that drives the cell row.
// ============================================================================
package mhpq_pkg;

    // Number of keys the queue can hold
    localparam int CAPACITY = 128;
    // Width of the key count, wide enough to hold CAPACITY itself
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int OCC_W    = 8;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [CNT_W-1:0]        t_count;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Input beat
    typedef struct packed {
        t_action action;
        t_key    key_in;
    } t_in;

    // Output beat
    typedef struct packed {
        t_key             key_out;
        t_status          status;
        logic [OCC_W-1:0] occupancy;
    } t_out;

    // Row operation broadcast to every cell
    typedef enum logic [1:0] {
        ROW_HOLD = 2'd0,
        ROW_PUSH = 2'd1,
        ROW_POP  = 2'd2
    } t_row_op;

    typedef struct packed {
        t_row_op op;
        t_key    key;
    } t_row_ctrl;

endpackage

// ===== rtl/mhpq_cell.sv =====
// ============================================================================
// mhpq_cell
// One slot of the sorted key row. Decides locally whether a new key belongs
// at or before this slot, and on a push or pop takes its value from the new
// key or from the neighbour on either side.
// ============================================================================
module mhpq_cell (
    input  logic               i_clk,
    input  mhpq_pkg::t_row_ctrl i_ctrl,
    input  logic               i_occupied,
    input  mhpq_pkg::t_key     i_left_key,
    input  logic               i_left_goes,
    input  mhpq_pkg::t_key     i_right_key,
    output mhpq_pkg::t_key     o_key,
    output logic               o_goes
);
    import mhpq_pkg::*;

    t_key r_key;
    t_key n_key;

    // New key lands here or further left: slot is free or holds a larger key
    assign o_goes = !i_occupied || (i_ctrl.key < r_key);
    assign o_key  = r_key;

    // Next slot value
    always_comb begin
        unique case (i_ctrl.op)
            ROW_PUSH: begin
                if (i_left_goes) begin
                    n_key = i_left_key;
                end else if (o_goes) begin
                    n_key = i_ctrl.key;
                end else begin
                    n_key = r_key;
                end
            end
            ROW_POP:  n_key = i_right_key;
            default:  n_key = r_key;
        endcase
    end

    // Slot payload, no reset needed: count says which slots are live
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

// ===== rtl/min_heap_priority_queue_top.sv =====
// ============================================================================
// min_heap_priority_queue_top
// Priority queue over signed 32-bit keys, smallest key out first. Keys are
// kept in ascending order in a row of cells; each beat inserts or removes.
// ============================================================================
//  channel | valid   | stall   | payload | direction
//  --------+---------+---------+---------+----------
//  input   | i_valid | o_stall | i_data  | in
//  output  | o_valid | i_stall | o_data  | out
//
//  Every cell compares the new key with its own in parallel and the row
//  shifts by one slot at the clock edge.
//  A new beat is taken while the output register is empty or being drained.
//  Synchronous active-low reset empties the queue; slot contents are left.
//  Stalling the output holds the result and stalls the input side.
// ============================================================================
module min_heap_priority_queue_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  mhpq_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output mhpq_pkg::t_out o_data
);
    import mhpq_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_out      r_out;
    t_out      n_out;
    t_count    r_count;
    t_count    n_count;
    logic      in_acc;
    logic      full;
    logic      empty;
    t_row_ctrl row_ctrl;
    t_key      cell_key  [CAPACITY];
    logic      cell_goes [CAPACITY];

    // Handshake
    assign o_stall = r_valid && i_stall;
    assign in_acc  = i_valid && !o_stall;
    assign full    = (r_count == t_count'(CAPACITY));
    assign empty   = (r_count == '0);

    // Row command and result
    always_comb begin
        row_ctrl.op  = ROW_HOLD;
        row_ctrl.key = i_data.key_in;
        n_count      = r_count;
        n_out        = r_out;
        if (in_acc) begin
            n_out.key_out = '0;
            n_out.status  = ST_OK;
            unique case (i_data.action)
                ACT_INSERT: begin
                    if (full) begin
                        n_out.status = ST_FULL;
                    end else begin
                        row_ctrl.op = ROW_PUSH;
                        n_count     = r_count + 1'b1;
                    end
                end
                ACT_REMOVE: begin
                    if (empty) begin
                        n_out.status = ST_EMPTY;
                    end else begin
                        row_ctrl.op   = ROW_POP;
                        n_out.key_out = cell_key[0];
                        n_count       = r_count - 1'b1;
                    end
                end
                default: n_out.status = ST_OK;
            endcase
            n_out.occupancy = OCC_W'(n_count);
        end
    end

    // Output valid
    always_comb begin
        if (in_acc) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;

    // Cell row, slot 0 holds the smallest key
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic occupied;
        t_key left_key;
        logic left_goes;
        t_key right_key;

        assign occupied = (t_count'(g) < r_count);

        if (g == 0) begin : g_first
            assign left_key  = i_data.key_in;
            assign left_goes = 1'b0;
        end else begin : g_inner
            assign left_key  = cell_key[g-1];
            assign left_goes = cell_goes[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_key = cell_key[g];
        end else begin : g_body
            assign right_key = cell_key[g+1];
        end

        mhpq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (row_ctrl),
            .i_occupied (occupied),
            .i_left_key (left_key),
            .i_left_goes(left_goes),
            .i_right_key(right_key),
            .o_key      (cell_key[g]),
            .o_goes     (cell_goes[g])
        );
    end

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(CAPACITY))
        else $error("key count above capacity");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_data.action == ACT_INSERT && full |=> full)
        else $error("insert into full queue changed the count");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_data.action == ACT_REMOVE && !empty
        |=> r_count == $past(r_count) - 1'b1)
        else $error("removal did not drop the count by one");

    a_row_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= t_count'(2) |-> !(cell_key[1] < cell_key[0]))
        else $error("head of the row out of order");

endmodule
